// ===== src/tfir_pkg.sv =====
// Shared constants, types and commands for the table-driven FIR filter.
package tfir_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int COEF_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 13;
    localparam int TAP_W      = HIST_AW + 1;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = PROD_W + HIST_AW;
    localparam int FRAC_W     = SAMPLE_W - 1;

    typedef enum logic [1:0] {
        CMD_FILTER = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_CLEAR  = 2'd2
    } tfir_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_MAC   = 4'b0100,
        ST_WAIT  = 4'b1000
    } tfir_state_t;

    typedef struct packed {
        logic clear;
        logic tap;
        logic finish;
    } tfir_mac_ctl_t;

endpackage

// ===== src/tfir_in_if.sv =====
// Input channel: command word with sample, tap window and coefficient write fields.
interface tfir_in_if import tfir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 command;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [11:0]                tap_offset;
    logic [12:0]                tap_count;
    logic [11:0]                coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;

    modport source (
        output valid, command, sample_in, tap_offset, tap_count, coef_index, coef_value,
        input  ready
    );
    modport sink (
        input  valid, command, sample_in, tap_offset, tap_count, coef_index, coef_value,
        output ready
    );
endinterface

// ===== src/tfir_out_if.sv =====
// Output channel: filtered sample and saturation flag.
interface tfir_out_if import tfir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    modport source (
        output valid, sample_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, sample_out, saturated,
        output ready
    );
endinterface

// ===== src/table_fir_filter.sv =====
// Top level of the table-driven direct-form FIR filter.
// A filter word stores its sample in the history and then runs one tap a cycle through a
// single multiply-accumulate fed by the history and coefficient memories, clamping the
// tap count to at most 4096, and takes no new word until its result is in the output
// register. Coefficient writes and unused commands leave the input ready. A clear-history
// word, and reset itself, start a pass over all 4096 history entries during
// which no word is taken; table_length may be written at any time.
module table_fir_filter import tfir_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    tfir_in_if.sink          in_word,
    tfir_out_if.source       out_word
);

    logic signed [SAMPLE_W-1:0] history_mem [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] coef_mem    [COEF_DEPTH];

    tfir_state_t                state_reg, state_next;
    logic [LEN_W-1:0]           table_length_reg;
    logic [HIST_AW-1:0]         wp_reg, wp_next;
    logic [TAP_W-1:0]           cnt_reg, cnt_next;
    logic [TAP_W-1:0]           n_reg, n_next;
    logic [HIST_AW-1:0]         base_reg, base_next;
    logic [COEF_AW-1:0]         off_reg, off_next;
    tfir_mac_ctl_t              ctl_reg, ctl_next;
    logic signed [SAMPLE_W-1:0] hist_rdata_reg;
    logic signed [SAMPLE_W-1:0] coef_rdata_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       saturated_reg;

    logic                       accept;
    logic [LEN_W-1:0]           len_eff;
    logic [LEN_W-1:0]           req_taps;
    logic [LEN_W-1:0]           avail;
    logic [TAP_W-1:0]           taps;
    logic                       hist_we;
    logic [HIST_AW-1:0]         hist_waddr;
    logic signed [SAMPLE_W-1:0] hist_wdata;
    logic                       coef_we;
    logic [HIST_AW-1:0]         hist_raddr;
    logic [COEF_AW-1:0]         coef_raddr;
    logic                       mac_done;
    logic signed [SAMPLE_W-1:0] mac_result;
    logic                       mac_sat;
    logic                       out_load;

    assign in_word.ready = (state_reg == ST_IDLE);
    assign accept        = in_word.valid && in_word.ready;

    // effective tap count
    always_comb
    begin
        len_eff  = (table_length_reg > LEN_W'(COEF_DEPTH)) ? LEN_W'(COEF_DEPTH)
                                                          : table_length_reg;
        req_taps = (in_word.tap_count > LEN_W'(HIST_DEPTH)) ? LEN_W'(HIST_DEPTH)
                                                           : in_word.tap_count;
        avail    = len_eff - LEN_W'(in_word.tap_offset);
        if (LEN_W'(in_word.tap_offset) >= len_eff)
            taps = '0;
        else if (req_taps > avail)
            taps = TAP_W'(avail);
        else
            taps = TAP_W'(req_taps);
    end

    assign hist_raddr = base_reg - cnt_reg[HIST_AW-1:0];
    assign coef_raddr = off_reg + cnt_reg[COEF_AW-1:0];
    assign out_load   = (state_reg == ST_WAIT) && mac_done
                        && (!out_valid_reg || out_word.ready);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        off_next   = off_reg;
        ctl_next   = '0;
        hist_we    = 1'b0;
        hist_waddr = wp_reg;
        hist_wdata = in_word.sample_in;
        coef_we    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = cnt_reg[HIST_AW-1:0];
                hist_wdata = '0;
                cnt_next   = cnt_reg + TAP_W'(1);
                if (cnt_reg[HIST_AW-1:0] == {HIST_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                    wp_next    = '0;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (tfir_cmd_t'(in_word.command))
                        CMD_FILTER:
                        begin
                            hist_we        = 1'b1;
                            base_next      = wp_reg;
                            wp_next        = wp_reg + HIST_AW'(1);
                            off_next       = COEF_AW'(in_word.tap_offset);
                            n_next         = taps;
                            cnt_next       = '0;
                            ctl_next.clear = 1'b1;
                            state_next     = ST_MAC;
                        end
                        CMD_COEF:
                        begin
                            coef_we = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                if (cnt_reg < n_reg)
                begin
                    ctl_next.tap = 1'b1;
                    cnt_next     = cnt_reg + TAP_W'(1);
                end
                else
                begin
                    ctl_next.finish = 1'b1;
                    state_next      = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_word.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            table_length_reg <= '0;
            wp_reg           <= '0;
            cnt_reg          <= '0;
            n_reg            <= '0;
            ctl_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            ctl_reg       <= ctl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                table_length_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        off_reg  <= off_next;
        if (out_load)
        begin
            sample_out_reg <= mac_result;
            saturated_reg  <= mac_sat;
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
            history_mem[hist_waddr] <= hist_wdata;
        hist_rdata_reg <= history_mem[hist_raddr];
    end

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[COEF_AW'(in_word.coef_index)] <= in_word.coef_value;
        coef_rdata_reg <= coef_mem[coef_raddr];
    end

    tfir_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_reg),
        .hist_data (hist_rdata_reg),
        .coef_data (coef_rdata_reg),
        .done      (mac_done),
        .result    (mac_result),
        .sat       (mac_sat)
    );

    assign out_word.valid      = out_valid_reg;
    assign out_word.sample_out = sample_out_reg;
    assign out_word.saturated  = saturated_reg;

endmodule

// ===== src/tfir_mac.sv =====
// Multiply-accumulate unit with round-half-up and saturation to Q1.15.
module tfir_mac import tfir_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tfir_mac_ctl_t              ctl,
    input  logic signed [SAMPLE_W-1:0] hist_data,
    input  logic signed [SAMPLE_W-1:0] coef_data,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] result,
    output logic                       sat
);

    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((2 ** FRAC_W) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(2 ** FRAC_W));
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(2 ** (FRAC_W - 1));

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       ptap_reg;
    logic                       pfin_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       afin_reg;
    logic                       done_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic                       sat_reg;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [SAMPLE_W-1:0] result_next;
    logic                       sat_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(hist_data) * PROD_W'(coef_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptap_reg <= 1'b0;
            pfin_reg <= 1'b0;
            afin_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ptap_reg <= ctl.tap;
            pfin_reg <= ctl.finish;
            afin_reg <= pfin_reg;
            if (ctl.clear)
                done_reg <= 1'b0;
            else if (afin_reg)
                done_reg <= 1'b1;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (ptap_reg)
            acc_next = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_comb
    begin
        rounded = (acc_reg + HALF) >>> FRAC_W;
        sat_next = 1'b0;
        if (rounded > OUT_MAX)
        begin
            result_next = OUT_MAX[SAMPLE_W-1:0];
            sat_next    = 1'b1;
        end
        else if (rounded < OUT_MIN)
        begin
            result_next = OUT_MIN[SAMPLE_W-1:0];
            sat_next    = 1'b1;
        end
        else
        begin
            result_next = rounded[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (afin_reg)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign sat    = sat_reg;

endmodule
